// ----- rtl/assert_macros.svh -----
// assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/sirt_pkg.sv -----
// shared types and constants for the radix text converter
package sirt_pkg;

    localparam int VALUE_W         = 32;
    localparam int CHAR_W          = 8;
    localparam int RADIX_W         = 5;
    localparam int SYM_W           = 64;
    localparam int SYM_COUNT       = 16;
    localparam int CFG_INDEX_W     = 2;
    localparam int DIGIT_W         = 4;
    localparam int DIGIT_DEPTH     = 32;
    localparam int DIGIT_IDX_W     = $clog2(DIGIT_DEPTH);
    localparam int CNT_W           = DIGIT_IDX_W + 1;
    localparam int STEPS_PER_CYCLE = 8;
    localparam int DIGIT_CYCLES    = VALUE_W / STEPS_PER_CYCLE;
    localparam int STEP_CNT_W      = $clog2(DIGIT_CYCLES);
    localparam int MAX_SYMBOLS_DEF = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_RADIX    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYM_LOW  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SYM_HIGH = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    typedef logic [1:0] emit_kind_t;
    localparam emit_kind_t EMIT_ERROR = 2'd0;
    localparam emit_kind_t EMIT_MINUS = 2'd1;
    localparam emit_kind_t EMIT_DIGIT = 2'd2;

    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       emit;
        emit_kind_t kind;
    } dp_cmd_t;

    typedef struct packed {
        logic alphabet_ok;
        logic value_neg;
        logic mag_zero;
        logic step_start;
        logic has_digits;
        logic cnt_one;
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/sirt_datapath.sv -----
// datapath: config registers, alphabet check, digit divider, digit store, output register
module sirt_datapath #(
    parameter int MAX_SYMBOLS = sirt_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sirt_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sirt_pkg::SYM_W-1:0]          cfg_data,
    input  logic [sirt_pkg::VALUE_W-1:0]        value,
    input  sirt_pkg::dp_cmd_t                   cmd,
    output sirt_pkg::dp_status_t                status,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [sirt_pkg::CHAR_W-1:0]         out_char,
    output logic                                out_last,
    output logic                                out_err
);
    import sirt_pkg::*;

    logic [RADIX_W-1:0]          radix_reg;
    logic [2*SYM_W-1:0]          symbols_reg;
    logic                        ok_reg;
    logic                        ok_next;
    logic [VALUE_W-1:0]          mag_reg;
    logic [VALUE_W-1:0]          mag_next;
    logic [DIGIT_W-1:0]          rem_reg;
    logic [DIGIT_W-1:0]          rem_next;
    logic                        neg_reg;
    logic [STEP_CNT_W-1:0]       step_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [DIGIT_W-1:0]          digits_reg [DIGIT_DEPTH];
    logic                        out_valid_reg;
    logic [CHAR_W-1:0]           out_char_reg;
    logic                        out_last_reg;
    logic                        out_err_reg;
    logic                        out_free;
    logic                        out_load;
    logic [CNT_W-1:0]            rd_cnt;
    logic [DIGIT_W-1:0]          rd_digit;
    logic [CHAR_W-1:0]           rd_char;
    logic                        last_step;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg   <= '0;
            symbols_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RADIX:    radix_reg <= cfg_data[RADIX_W-1:0];
                REG_SYM_LOW:  symbols_reg[SYM_W-1:0] <= cfg_data;
                REG_SYM_HIGH: symbols_reg[2*SYM_W-1:SYM_W] <= cfg_data;
                default:      ;
            endcase
        end
    end

    // alphabet check, registered
    always_comb
    begin
        logic [CHAR_W-1:0] si;
        logic              use_i;
        logic              use_j;
        ok_next = (radix_reg >= RADIX_W'(2)) && (radix_reg <= RADIX_W'(MAX_SYMBOLS));
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            si    = symbols_reg[i*CHAR_W +: CHAR_W];
            use_i = RADIX_W'(i) < radix_reg;
            if (use_i && (si == CHAR_NUL || si == CHAR_PLUS || si == CHAR_MINUS))
                ok_next = 1'b0;
            for (int j = i + 1; j < MAX_SYMBOLS; j++)
            begin
                use_j = RADIX_W'(j) < radix_reg;
                if (use_j && si == symbols_reg[j*CHAR_W +: CHAR_W])
                    ok_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ok_reg <= 1'b0;
        else
            ok_reg <= ok_next;
    end

    // restoring division, eight quotient bits a cycle
    always_comb
    begin
        logic [DIGIT_W:0] t;
        rem_next = (step_reg == '0) ? '0 : rem_reg;
        mag_next = mag_reg;
        for (int k = 0; k < STEPS_PER_CYCLE; k++)
        begin
            t        = {rem_next, mag_next[VALUE_W-1]};
            mag_next = {mag_next[VALUE_W-2:0], 1'b0};
            if (t >= (DIGIT_W+1)'(radix_reg))
            begin
                t           = t - (DIGIT_W+1)'(radix_reg);
                mag_next[0] = 1'b1;
            end
            rem_next = t[DIGIT_W-1:0];
        end
    end

    assign last_step = step_reg == STEP_CNT_W'(DIGIT_CYCLES - 1);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg <= value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
            neg_reg <= value[VALUE_W-1];
        end
        else if (cmd.div_step)
        begin
            mag_reg <= mag_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_step && last_step && !cnt_reg[CNT_W-1])
            digits_reg[cnt_reg[DIGIT_IDX_W-1:0]] <= rem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.load)
        begin
            step_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            step_reg <= step_reg + STEP_CNT_W'(1);
            if (last_step && !cnt_reg[CNT_W-1])
                cnt_reg <= cnt_reg + CNT_W'(1);
        end
        else if (out_load && cmd.kind == EMIT_DIGIT)
            cnt_reg <= cnt_reg - CNT_W'(1);
    end

    // digit readout
    assign rd_cnt   = cnt_reg - CNT_W'(1);
    assign rd_digit = digits_reg[rd_cnt[DIGIT_IDX_W-1:0]];
    assign rd_char  = symbols_reg[rd_digit*CHAR_W +: CHAR_W];

    // output register
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = cmd.emit && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            unique case (cmd.kind)
                EMIT_ERROR:
                begin
                    out_char_reg <= CHAR_NUL;
                    out_last_reg <= 1'b1;
                    out_err_reg  <= 1'b1;
                end
                EMIT_MINUS:
                begin
                    out_char_reg <= CHAR_MINUS;
                    out_last_reg <= 1'b0;
                    out_err_reg  <= 1'b0;
                end
                default:
                begin
                    out_char_reg <= rd_char;
                    out_last_reg <= cnt_reg == CNT_W'(1);
                    out_err_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;
    assign out_err   = out_err_reg;

    assign status.alphabet_ok = ok_reg;
    assign status.value_neg   = neg_reg;
    assign status.mag_zero    = mag_reg == '0;
    assign status.step_start  = step_reg == '0;
    assign status.has_digits  = cnt_reg != '0;
    assign status.cnt_one     = cnt_reg == CNT_W'(1);
    assign status.out_free    = out_free;

endmodule

// ----- rtl/sirt_ctrl.sv -----
// controller state machine for the radix text converter
module sirt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sirt_pkg::dp_status_t status,
    output sirt_pkg::dp_cmd_t    cmd
);
    import sirt_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_SIGN   = 3'd3;
    localparam logic [2:0] S_DIGITS = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.div_step = 1'b0;
        cmd.emit     = 1'b0;
        cmd.kind     = EMIT_DIGIT;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!status.alphabet_ok)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = EMIT_ERROR;
                    if (status.out_free)
                        state_next = S_IDLE;
                end
                else
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                // quotient exhausted after at least one digit
                if (status.step_start && status.has_digits && status.mag_zero)
                    state_next = S_SIGN;
                else
                    cmd.div_step = 1'b1;
            end
            S_SIGN:
            begin
                if (status.value_neg)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = EMIT_MINUS;
                    if (status.out_free)
                        state_next = S_DIGITS;
                end
                else
                    state_next = S_DIGITS;
            end
            S_DIGITS:
            begin
                cmd.emit = 1'b1;
                cmd.kind = EMIT_DIGIT;
                if (status.out_free && status.cnt_one)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// ----- rtl/signed_int_to_radix_text.sv -----
// top level of the signed integer to radix text converter
//
//  channel   dir  tdata / payload            handshake
//  s_axis    in   value[31:0]                s_tvalid / s_tready
//  m_axis    out  character[7:0], tlast,     m_tvalid / m_tready
//                 tuser = invalid_base
//  cfg       in   cfg_index, cfg_data[63:0]  cfg_valid / cfg_ready
//
// per value with d digits: a check state, the divider state, a sign state that
// emits a minus for a negative value, and d character beats; when the alphabet
// check fails, a single error beat ends the value instead
// input is taken only while idle; output stalls hold the controller
// the alphabet check is registered from the config registers
// reset clears config to zero and the controller to idle
module signed_int_to_radix_text #(
    parameter int MAX_SYMBOLS = sirt_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sirt_pkg::VALUE_W-1:0]     s_tdata,   // value[31:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sirt_pkg::CHAR_W-1:0]      m_tdata,   // character[7:0]
    output logic                             m_tlast,
    output logic                             m_tuser,   // invalid_base
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sirt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sirt_pkg::SYM_W-1:0]       cfg_data
);
    import sirt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    sirt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sirt_datapath #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .value     (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_char  (m_tdata),
        .out_last  (m_tlast),
        .out_err   (m_tuser)
    );

endmodule

// ----- rtl/sirt_checker.sv -----
// port-level checker for the radix text converter, bound to the top level
`include "assert_macros.svh"

module sirt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    logic [9:0] m_beat;

    assign m_beat = {m_tuser, m_tlast, m_tdata};

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_beat))
    `ASSERT_IMPL(a_err_beat, clk, rst_n, m_tvalid && m_tuser, m_tlast && m_tdata == 8'h00)
    `ASSERT_IMPL(a_busy_mid_text, clk, rst_n, m_tvalid && !m_tlast, !s_tready)
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready)

endmodule

bind signed_int_to_radix_text sirt_checker u_sirt_checker (.*);
